// File: design/cpm_pkg.sv
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared codes, types and the permutation table of the cluster label
// permutation match unit.
// ----------------------------------------------------------------------------
package cpm_pkg;

   localparam int DEFAULT_MAX_ITEMS = 256;
   localparam int PERM_COUNT        = 6;
   localparam int SAT_MAX           = 511;

   localparam logic [1:0] FUNC_APPEND  = 2'd0;
   localparam logic [1:0] FUNC_READ    = 2'd1;
   localparam logic [1:0] FUNC_RESTART = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BAD   = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_RANGE = 2'd3;

   localparam logic [1:0] LABEL_INVALID = 2'd3;

   // permutations of {0,1,2} in lexicographic order
   localparam logic [1:0] PERM_TABLE [PERM_COUNT][3] = '{
      '{2'd0, 2'd1, 2'd2},
      '{2'd0, 2'd2, 2'd1},
      '{2'd1, 2'd0, 2'd2},
      '{2'd1, 2'd2, 2'd0},
      '{2'd2, 2'd0, 2'd1},
      '{2'd2, 2'd1, 2'd0}
   };

   typedef struct packed {
      logic       clear;
      logic       update;
      logic [1:0] target_label;
      logic [1:0] sample_label;
   } cnt_cmd_type;

   function automatic logic [1:0] perm_map(input logic [2:0] perm, input logic [1:0] lbl);
      logic [1:0] result;
      result = 2'd0;
      if ((perm < 3'(PERM_COUNT)) && (lbl != LABEL_INVALID)) begin
         result = PERM_TABLE[perm][lbl];
      end
      return result;
   endfunction

endpackage

// File: design/cpm_label_mem.sv
// ----------------------------------------------------------------------------
// cpm_label_mem
// Label store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cpm_label_mem #(
   parameter  int DEPTH = cpm_pkg::DEFAULT_MAX_ITEMS,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [1:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [1:0]    rd_data
);

   logic [1:0] label_store_ff [DEPTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         label_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= label_store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/cpm_perm_counters.sv
// ----------------------------------------------------------------------------
// cpm_perm_counters
// Six mismatch counters, one per permutation, with a best-permutation
// select tree (ties go to the earlier permutation).
// ----------------------------------------------------------------------------
module cpm_perm_counters #(
   parameter int CNT_W = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cpm_pkg::cnt_cmd_type     cmd,
   output logic [2:0]               best_perm,
   output logic [CNT_W-1:0]         min_count
);

   logic [CNT_W-1:0] count_ff [cpm_pkg::PERM_COUNT];
   logic [CNT_W-1:0] count_in [cpm_pkg::PERM_COUNT];

   logic [CNT_W-1:0] l1_val [3];
   logic [2:0]       l1_idx [3];
   logic [CNT_W-1:0] l2_val;
   logic [2:0]       l2_idx;

   always_comb begin
      for (int p = 0; p < cpm_pkg::PERM_COUNT; p++) begin
         count_in[p] = count_ff[p];
         if (cmd.clear) begin
            count_in[p] = '0;
         end else if (cmd.update &&
                      (cmd.target_label != cpm_pkg::perm_map(3'(p), cmd.sample_label))) begin
            count_in[p] = count_ff[p] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < cpm_pkg::PERM_COUNT; p++) begin
         if (reset) begin
            count_ff[p] <= '0;
         end else begin
            count_ff[p] <= count_in[p];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (count_ff[2*k+1] < count_ff[2*k]) begin
            l1_val[k] = count_ff[2*k+1];
            l1_idx[k] = 3'(2*k+1);
         end else begin
            l1_val[k] = count_ff[2*k];
            l1_idx[k] = 3'(2*k);
         end
      end
      if (l1_val[1] < l1_val[0]) begin
         l2_val = l1_val[1];
         l2_idx = l1_idx[1];
      end else begin
         l2_val = l1_val[0];
         l2_idx = l1_idx[0];
      end
      if (l1_val[2] < l2_val) begin
         min_count = l1_val[2];
         best_perm = l1_idx[2];
      end else begin
         min_count = l2_val;
         best_perm = l2_idx;
      end
   end

endmodule

// File: design/cluster_label_permutation_match_unit.sv
// ----------------------------------------------------------------------------
// cluster_label_permutation_match_unit
// Stores cluster labels, counts mismatches for the six permutations of
// {0,1,2} and reads stored labels back through the best permutation.
// ----------------------------------------------------------------------------
// usage:
//   request channel: req_func, req_target_label, req_sample_label and
//   req_read_index are taken in a transfer at a clock edge with start high
//   and busy low. func 0 appends a label pair, 1 reads entry req_read_index
//   through the best permutation, 2 restarts the set.
//   response channel: every request gives exactly one response. rsp_valid
//   is high for one cycle and the rsp_ ports hold the result in that cycle;
//   the receiver cannot stall it.
//   busy: no new request is taken while busy is high; busy is high for
//   the cycle in which the label store read data returns and the best
//   permutation is picked from the six counters, and the response
//   registers are loaded from them at the end of that cycle.
//   reset: clears the item count, counters, bad flag and handshake state;
//   the label store holds no valid data until written.
// ----------------------------------------------------------------------------
module cluster_label_permutation_match_unit #(
   parameter int MAX_ITEMS = cpm_pkg::DEFAULT_MAX_ITEMS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [1:0] req_target_label,
   input  logic [1:0] req_sample_label,
   input  logic [7:0] req_read_index,
   output logic       rsp_valid,
   output logic [1:0] rsp_mapped_label,
   output logic [8:0] rsp_least_mismatch,
   output logic [8:0] rsp_stored_count,
   output logic [1:0] rsp_status
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int RW = (CW > 8) ? CW : 8;
   localparam int SW = (CW > 9) ? CW : 9;
   localparam int IW = (AW > 8) ? AW : 8;

   logic          busy_ff, busy_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] count_ff, count_in;
   logic          bad_ff, bad_in;
   logic [1:0]    status_ff, status_in;
   logic          read_ok_ff, read_ok_in;
   logic          min_zero_ff, min_zero_in;

   logic [1:0]    rsp_mapped_label_ff, rsp_mapped_label_in;
   logic [8:0]    rsp_least_mismatch_ff, rsp_least_mismatch_in;
   logic [8:0]    rsp_stored_count_ff, rsp_stored_count_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          accept;
   logic          is_append, is_read, is_restart;
   logic          full, append_ok, set_bad;
   logic [IW-1:0] idx_ext;
   logic          idx_range;
   logic [1:0]    rd_data, rd_label;
   logic [2:0]    best_perm;
   logic [CW-1:0] min_count;
   logic [SW-1:0] count_sw, min_sw;

   cpm_pkg::cnt_cmd_type cnt_cmd;

   assign accept     = start && !busy_ff;
   assign is_append  = (req_func == cpm_pkg::FUNC_APPEND);
   assign is_read    = (req_func == cpm_pkg::FUNC_READ);
   assign is_restart = (req_func == cpm_pkg::FUNC_RESTART);
   assign full       = (count_ff == CW'(MAX_ITEMS));
   assign append_ok  = is_append && !full && (req_sample_label != cpm_pkg::LABEL_INVALID);
   assign set_bad    = is_append && !full && (req_sample_label == cpm_pkg::LABEL_INVALID);
   assign idx_ext    = IW'(req_read_index);
   assign idx_range  = (RW'(req_read_index) >= RW'(count_ff));

   assign cnt_cmd.clear        = accept && is_restart;
   assign cnt_cmd.update       = accept && append_ok;
   assign cnt_cmd.target_label = req_target_label;
   assign cnt_cmd.sample_label = req_sample_label;

   cpm_label_mem #(
      .DEPTH (MAX_ITEMS)
   ) u_label_mem (
      .clock   (clock),
      .wr_en   (accept && append_ok),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_sample_label),
      .rd_en   (accept && is_read),
      .rd_addr (idx_ext[AW-1:0]),
      .rd_data (rd_data)
   );

   cpm_perm_counters #(
      .CNT_W (CW)
   ) u_perm_counters (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cnt_cmd),
      .best_perm (best_perm),
      .min_count (min_count)
   );

   // request side
   always_comb begin
      busy_in     = accept;
      count_in    = count_ff;
      bad_in      = bad_ff;
      status_in   = status_ff;
      read_ok_in  = read_ok_ff;
      min_zero_in = min_zero_ff;
      if (accept) begin
         if (is_restart) begin
            count_in = '0;
            bad_in   = 1'b0;
         end else if (append_ok) begin
            count_in = count_ff + 1'b1;
         end else if (set_bad) begin
            bad_in = 1'b1;
         end
         priority if (is_append && full) begin
            status_in = cpm_pkg::STATUS_FULL;
         end else if (bad_in) begin
            status_in = cpm_pkg::STATUS_BAD;
         end else if (is_read && idx_range) begin
            status_in = cpm_pkg::STATUS_RANGE;
         end else begin
            status_in = cpm_pkg::STATUS_OK;
         end
         read_ok_in  = is_read && !bad_in && !idx_range;
         min_zero_in = bad_in;
      end
   end

   // response side
   assign rd_label = (rd_data == cpm_pkg::LABEL_INVALID) ? 2'd0 : rd_data;
   assign count_sw = SW'(count_ff);
   assign min_sw   = SW'(min_count);

   always_comb begin
      rsp_valid_in          = busy_ff;
      rsp_mapped_label_in   = rsp_mapped_label_ff;
      rsp_least_mismatch_in = rsp_least_mismatch_ff;
      rsp_stored_count_in   = rsp_stored_count_ff;
      rsp_status_in         = rsp_status_ff;
      if (busy_ff) begin
         rsp_mapped_label_in = read_ok_ff ? cpm_pkg::perm_map(best_perm, rd_label) : 2'd0;
         if (min_zero_ff) begin
            rsp_least_mismatch_in = 9'd0;
         end else if (min_sw > SW'(cpm_pkg::SAT_MAX)) begin
            rsp_least_mismatch_in = 9'(cpm_pkg::SAT_MAX);
         end else begin
            rsp_least_mismatch_in = min_sw[8:0];
         end
         if (count_sw > SW'(cpm_pkg::SAT_MAX)) begin
            rsp_stored_count_in = 9'(cpm_pkg::SAT_MAX);
         end else begin
            rsp_stored_count_in = count_sw[8:0];
         end
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         bad_ff       <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         bad_ff       <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff             <= status_in;
      read_ok_ff            <= read_ok_in;
      min_zero_ff           <= min_zero_in;
      rsp_mapped_label_ff   <= rsp_mapped_label_in;
      rsp_least_mismatch_ff <= rsp_least_mismatch_in;
      rsp_stored_count_ff   <= rsp_stored_count_in;
      rsp_status_ff         <= rsp_status_in;
   end

   assign busy               = busy_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mapped_label   = rsp_mapped_label_ff;
   assign rsp_least_mismatch = rsp_least_mismatch_ff;
   assign rsp_stored_count   = rsp_stored_count_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef SYNTH
   a_busy_then_rsp: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_valid_ff)
      else $error("response missing after busy cycle");

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("response while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      RW'(count_ff) <= RW'(MAX_ITEMS))
      else $error("item count above store depth");

   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && is_restart) |=> ##1 (rsp_stored_count_ff == 9'd0 &&
         rsp_least_mismatch_ff == 9'd0 && rsp_status_ff == cpm_pkg::STATUS_OK))
      else $error("restart response not cleared");

   a_mapped_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != cpm_pkg::STATUS_OK) |-> rsp_mapped_label_ff == 2'd0)
      else $error("mapped label on failed request");
`endif

endmodule

// File: tb/cluster_label_permutation_match_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cluster_label_permutation_match_unit_tb
// Self-checking bench: a queue of label pair, read, restart and unused-code requests is
// driven through the start/busy handshake in random bursts. Every response
// is compared field by field against a behavioral predictor that keeps its
// own copy of the label store, mismatch counters and bad label flag.
// ----------------------------------------------------------------------------
module cluster_label_permutation_match_unit_tb;

   localparam logic [1:0] FUNC_UNUSED    = 2'd3;
   localparam int         ITEM_GOAL      = 1050;
   localparam int         WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [1:0] func;
      logic [1:0] target_label;
      logic [1:0] sample_label;
      logic [7:0] read_index;
   } label_req_type;

   typedef struct packed {
      logic [1:0] mapped_label;
      logic [8:0] least_mismatch;
      logic [8:0] stored_count;
      logic [1:0] status;
   } match_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_func = cpm_pkg::FUNC_RESTART;
   logic [1:0] req_target_label = 2'd0;
   logic [1:0] req_sample_label = 2'd0;
   logic [7:0] req_read_index = 8'd0;
   logic       rsp_valid;
   logic [1:0] rsp_mapped_label;
   logic [8:0] rsp_least_mismatch;
   logic [8:0] rsp_stored_count;
   logic [1:0] rsp_status;

   label_req_type  queued_requests[$];
   match_rsp_type  expected_matches[$];

   // predictor state
   logic [1:0]  shadow_labels [cpm_pkg::DEFAULT_MAX_ITEMS];
   int unsigned shadow_count;
   int unsigned shadow_miss [cpm_pkg::PERM_COUNT];
   bit          shadow_poisoned;

   // generator side view of the stored count
   int unsigned gen_count;

   logic          item_taken = 1'b0;
   int unsigned   burst_left = 6;
   int unsigned   gap_left = 0;
   label_req_type drv_req;
   label_req_type mon_req;
   match_rsp_type got_rsp;
   match_rsp_type want_rsp;
   match_rsp_type next_rsp;
   int unsigned   idle_cycles = 0;
   int unsigned   fail_count = 0;
   int unsigned   n_accepted = 0;
   int unsigned   n_results = 0;
   int unsigned   n_mapped = 0;
   int unsigned   n_full = 0;
   int unsigned   n_bad = 0;
   int unsigned   n_range = 0;

   cluster_label_permutation_match_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_target_label   (req_target_label),
      .req_sample_label   (req_sample_label),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_mapped_label   (rsp_mapped_label),
      .rsp_least_mismatch (rsp_least_mismatch),
      .rsp_stored_count   (rsp_stored_count),
      .rsp_status         (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned best_permutation();
      int unsigned best;
      int unsigned p;
      best = 0;
      for (p = 1; p < cpm_pkg::PERM_COUNT; p++) begin
         if (shadow_miss[p] < shadow_miss[best]) begin
            best = p;
         end
      end
      return best;
   endfunction

   function automatic match_rsp_type predict_match(input label_req_type r);
      match_rsp_type e;
      int unsigned p;
      e = '0;
      e.status = cpm_pkg::STATUS_OK;
      unique case (r.func)
         cpm_pkg::FUNC_APPEND: begin
            if (shadow_count >= cpm_pkg::DEFAULT_MAX_ITEMS) begin
               e.status = cpm_pkg::STATUS_FULL;
            end else if (r.sample_label == cpm_pkg::LABEL_INVALID) begin
               shadow_poisoned = 1'b1;
            end else begin
               shadow_labels[shadow_count] = r.sample_label;
               shadow_count++;
               for (p = 0; p < cpm_pkg::PERM_COUNT; p++) begin
                  if (r.target_label != cpm_pkg::PERM_TABLE[p][r.sample_label]) begin
                     shadow_miss[p]++;
                  end
               end
            end
         end
         cpm_pkg::FUNC_READ: begin
            if (!shadow_poisoned) begin
               if (r.read_index >= shadow_count) begin
                  e.status = cpm_pkg::STATUS_RANGE;
               end else begin
                  e.mapped_label =
                     cpm_pkg::PERM_TABLE[best_permutation()][shadow_labels[r.read_index]];
               end
            end
         end
         cpm_pkg::FUNC_RESTART: begin
            shadow_count = 0;
            for (p = 0; p < cpm_pkg::PERM_COUNT; p++) begin
               shadow_miss[p] = 0;
            end
            shadow_poisoned = 1'b0;
         end
         default: begin
         end
      endcase
      if (shadow_poisoned && e.status != cpm_pkg::STATUS_FULL) begin
         e.status = cpm_pkg::STATUS_BAD;
         e.mapped_label = 2'd0;
      end
      e.least_mismatch = shadow_poisoned ? 9'd0 : 9'(shadow_miss[best_permutation()]);
      e.stored_count = 9'(shadow_count);
      return e;
   endfunction

   task automatic queue_req(input logic [1:0] func, input logic [1:0] tgt,
                            input logic [1:0] smp, input logic [7:0] idx);
      label_req_type r;
      r.func = func;
      r.target_label = tgt;
      r.sample_label = smp;
      r.read_index = idx;
      queued_requests = {queued_requests, r};
      if (func == cpm_pkg::FUNC_RESTART) begin
         gen_count = 0;
      end else if (func == cpm_pkg::FUNC_APPEND && smp != cpm_pkg::LABEL_INVALID
                   && gen_count < cpm_pkg::DEFAULT_MAX_ITEMS) begin
         gen_count++;
      end
   endtask

   task automatic check_field(input string field, input logic [8:0] want,
                              input logic [8:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (gap_left > 0 || queued_requests.size() == 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end
            start <= 1'b0;
         end else begin
            drv_req = queued_requests.pop_front();
            req_func <= drv_req.func;
            req_target_label <= drv_req.target_label;
            req_sample_label <= drv_req.sample_label;
            req_read_index <= drv_req.read_index;
            start <= 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      item_taken <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            got_rsp.mapped_label = rsp_mapped_label;
            got_rsp.least_mismatch = rsp_least_mismatch;
            got_rsp.stored_count = rsp_stored_count;
            got_rsp.status = rsp_status;
            if (expected_matches.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want_rsp = expected_matches.pop_front();
               check_field("mapped_label", 9'(want_rsp.mapped_label), 9'(got_rsp.mapped_label));
               check_field("least_mismatch", want_rsp.least_mismatch, got_rsp.least_mismatch);
               check_field("stored_count", want_rsp.stored_count, got_rsp.stored_count);
               check_field("status", 9'(want_rsp.status), 9'(got_rsp.status));
               n_results++;
               unique case (want_rsp.status)
                  cpm_pkg::STATUS_FULL:  n_full++;
                  cpm_pkg::STATUS_BAD:   n_bad++;
                  cpm_pkg::STATUS_RANGE: n_range++;
                  default:               if (want_rsp.mapped_label != 2'd0) n_mapped++;
               endcase
            end
         end
         if (start && !busy) begin
            mon_req.func = req_func;
            mon_req.target_label = req_target_label;
            mon_req.sample_label = req_sample_label;
            mon_req.read_index = req_read_index;
            next_rsp = predict_match(mon_req);
            expected_matches = {expected_matches, next_rsp};
            n_accepted++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned total;
      int          set_no;
      int          set_len;
      int          append_pct;
      int          hidden_perm;
      int          pick;
      bit          clean_set;
      logic [1:0]  tgt;
      logic [1:0]  smp;
      logic [7:0]  idx;

      shadow_count = 0;
      shadow_poisoned = 1'b0;
      for (int p = 0; p < cpm_pkg::PERM_COUNT; p++) begin
         shadow_miss[p] = 0;
      end
      gen_count = 0;

      // directed part
      queue_req(cpm_pkg::FUNC_RESTART, 2'd0, 2'd0, 8'd0);
      queue_req(FUNC_UNUSED, 2'd3, 2'd3, 8'hff);
      queue_req(cpm_pkg::FUNC_READ, 2'd0, 2'd0, 8'd0);
      queue_req(cpm_pkg::FUNC_APPEND, 2'd0, 2'd0, 8'd0);
      queue_req(cpm_pkg::FUNC_APPEND, 2'd1, 2'd1, 8'd0);
      queue_req(cpm_pkg::FUNC_APPEND, 2'd2, 2'd2, 8'd0);
      queue_req(cpm_pkg::FUNC_APPEND, 2'd3, 2'd1, 8'd0);
      queue_req(cpm_pkg::FUNC_APPEND, 2'd2, 2'd0, 8'd0);
      queue_req(cpm_pkg::FUNC_APPEND, 2'd0, 2'd2, 8'd0);
      queue_req(cpm_pkg::FUNC_READ, 2'd0, 2'd0, 8'd0);
      queue_req(cpm_pkg::FUNC_READ, 2'd0, 2'd0, 8'd5);
      queue_req(cpm_pkg::FUNC_READ, 2'd0, 2'd0, 8'd6);
      queue_req(cpm_pkg::FUNC_READ, 2'd0, 2'd0, 8'hff);
      queue_req(FUNC_UNUSED, 2'd0, 2'd0, 8'd0);
      queue_req(cpm_pkg::FUNC_APPEND, 2'd1, cpm_pkg::LABEL_INVALID, 8'd0);
      queue_req(cpm_pkg::FUNC_APPEND, 2'd1, 2'd2, 8'd0);
      queue_req(cpm_pkg::FUNC_READ, 2'd0, 2'd0, 8'd0);
      queue_req(cpm_pkg::FUNC_READ, 2'd0, 2'd0, 8'd200);
      queue_req(FUNC_UNUSED, 2'd0, 2'd0, 8'd0);
      queue_req(cpm_pkg::FUNC_RESTART, 2'd3, 2'd3, 8'hff);
      queue_req(cpm_pkg::FUNC_APPEND, 2'd1, 2'd0, 8'd0);
      queue_req(cpm_pkg::FUNC_READ, 2'd0, 2'd0, 8'd0);
      queue_req(cpm_pkg::FUNC_APPEND, 2'd3, 2'd2, 8'd0);
      queue_req(cpm_pkg::FUNC_READ, 2'd0, 2'd0, 8'd1);

      // random sets, each opened by a restart; two of them fill the store
      for (set_no = 0; queued_requests.size() < ITEM_GOAL; set_no++) begin
         clean_set = (set_no == 2);
         set_len = (set_no == 2 || set_no == 11) ? 300 : $urandom_range(3, 40);
         append_pct = (set_len == 300) ? 93 : 55;
         hidden_perm = $urandom_range(0, cpm_pkg::PERM_COUNT - 1);
         queue_req(cpm_pkg::FUNC_RESTART, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)));
         repeat (set_len) begin
            pick = $urandom_range(0, 99);
            smp = 2'($urandom_range(0, 2));
            tgt = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3))
                                              : cpm_pkg::PERM_TABLE[hidden_perm][smp];
            idx = 8'($urandom_range(0, 255));
            if (pick == 99 && !clean_set) begin
               queue_req(cpm_pkg::FUNC_APPEND, tgt, cpm_pkg::LABEL_INVALID, idx);
            end else if (pick < append_pct || pick == 99) begin
               queue_req(cpm_pkg::FUNC_APPEND, tgt, smp, idx);
            end else if (pick < 96) begin
               if (gen_count > 0 && $urandom_range(0, 3) != 0) begin
                  idx = 8'($urandom_range(0, gen_count - 1));
               end
               queue_req(cpm_pkg::FUNC_READ, tgt, smp, idx);
            end else begin
               queue_req(FUNC_UNUSED, tgt, smp, idx);
            end
         end
      end
      total = queued_requests.size();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      while (n_accepted < total) @(posedge clock);
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("%0d requests in %0d random sets, %0d responses checked", total, set_no,
               n_results);
      $display("remapped reads %0d, store full %0d, bad label %0d, out of range %0d",
               n_mapped, n_full, n_bad, n_range);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/cpm_pkg.sv
design/cpm_label_mem.sv
design/cpm_perm_counters.sv
design/cluster_label_permutation_match_unit.sv
tb/cluster_label_permutation_match_unit_tb.sv
